/* rtl/deadline_sleep_queue_top_assert.svh */
// Assertion macros for the sleep queue; clk and rst_n come from the including module.
`ifndef DEADLINE_SLEEP_QUEUE_TOP_ASSERT_SVH
`define DEADLINE_SLEEP_QUEUE_TOP_ASSERT_SVH

// Same-cycle implication.
`define DSQ_ASSERT_NOW(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error(msg);

// Next-cycle implication.
`define DSQ_ASSERT_NEXT(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error(msg);

`endif

/* rtl/dsq_pkg.sv */
`timescale 1ns / 1ps
`default_nettype none
package dsq_pkg;

  localparam int QUEUE_DEPTH = 16;
  localparam int ID_BITS     = 8;
  localparam int TICK_BITS   = 63;
  localparam int REQ_BITS    = 31;

  localparam logic FN_TICK = 1'b0;

  typedef logic [ID_BITS-1:0]   id_t;
  typedef logic [TICK_BITS-1:0] tick_t;

  typedef enum logic [1:0] {
    ST_WOKEN     = 2'd0,
    ST_IMMEDIATE = 2'd1,
    ST_FULL      = 2'd2
  } status_t;

  typedef enum logic [1:0] {
    CELL_HOLD,
    CELL_INSERT,
    CELL_POP
  } cell_op_t;

  typedef enum logic [2:0] {
    S_IDLE,
    S_POP,
    S_ADD,
    S_INSERT,
    S_REPLY
  } state_t;

  typedef struct packed {
    logic  valid;
    tick_t wake;
    id_t   id;
  } entry_t;

  typedef struct packed {
    cell_op_t op;
    tick_t    key;
    tick_t    tick;
    id_t      id;
  } cell_cmd_t;

endpackage
`default_nettype wire

/* rtl/dsq_if.sv */
`timescale 1ns / 1ps
`default_nettype none
interface dsq_in_if;
  logic               valid;
  logic               ready;
  logic               func;
  logic [7:0]         thread_id;
  logic signed [31:0] sleep_ticks;

  modport source (output valid, func, thread_id, sleep_ticks, input ready);
  modport sink (input valid, func, thread_id, sleep_ticks, output ready);
endinterface

interface dsq_out_if;
  logic        valid;
  logic        ready;
  logic [7:0]  woken_id;
  logic [1:0]  status;
  logic [62:0] now_tick;
  logic        last;

  modport source (output valid, woken_id, status, now_tick, last, input ready);
  modport sink (input valid, woken_id, status, now_tick, last, output ready);
endinterface
`default_nettype wire

/* rtl/dsq_cell.sv */
`timescale 1ns / 1ps
`default_nettype none
module dsq_cell import dsq_pkg::*; (
  input  logic      clk,
  input  logic      rst_n,
  input  cell_cmd_t cmd,
  input  entry_t    left_ent,
  input  logic      left_keep,
  input  entry_t    right_ent,
  output entry_t    ent_o,
  output logic      keep_o,
  output logic      due_o
);

  logic  valid_r, valid_nxt;
  tick_t wake_r, wake_nxt;
  id_t   id_r, id_nxt;

  assign keep_o = valid_r && (wake_r <= cmd.key);
  assign due_o  = valid_r && (wake_r <= cmd.tick);
  assign ent_o  = '{valid: valid_r, wake: wake_r, id: id_r};

  always_comb begin
    valid_nxt = valid_r;
    wake_nxt  = wake_r;
    id_nxt    = id_r;
    case (cmd.op)
      CELL_INSERT: begin
        if (!keep_o) begin
          if (left_keep) begin
            valid_nxt = 1'b1;
            wake_nxt  = cmd.key;
            id_nxt    = cmd.id;
          end else begin
            valid_nxt = left_ent.valid;
            wake_nxt  = left_ent.wake;
            id_nxt    = left_ent.id;
          end
        end
      end
      CELL_POP: begin
        valid_nxt = right_ent.valid;
        wake_nxt  = right_ent.wake;
        id_nxt    = right_ent.id;
      end
      default: begin
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      valid_r <= 1'b0;
    end else begin
      valid_r <= valid_nxt;
    end
  end

  always_ff @(posedge clk) begin
    wake_r <= wake_nxt;
    id_r   <= id_nxt;
  end

endmodule
`default_nettype wire

/* rtl/dsq_chain.sv */
`timescale 1ns / 1ps
`default_nettype none
module dsq_chain import dsq_pkg::*; (
  input  logic                   clk,
  input  logic                   rst_n,
  input  cell_cmd_t              cmd,
  output entry_t                 ent_o [QUEUE_DEPTH],
  output logic [QUEUE_DEPTH-1:0] valid_o,
  output logic [QUEUE_DEPTH-1:0] due_o
);

  entry_t ent   [QUEUE_DEPTH];
  entry_t left  [QUEUE_DEPTH];
  entry_t right [QUEUE_DEPTH];
  logic [QUEUE_DEPTH-1:0] keep;
  logic [QUEUE_DEPTH-1:0] left_keep;

  for (genvar i = 0; i < QUEUE_DEPTH; i++) begin : g_cell
    if (i == 0) begin : g_head
      assign left[i]      = '0;
      assign left_keep[i] = 1'b1;
    end else begin : g_body
      assign left[i]      = ent[i-1];
      assign left_keep[i] = keep[i-1];
    end
    if (i == QUEUE_DEPTH - 1) begin : g_tail
      assign right[i] = '0;
    end else begin : g_mid
      assign right[i] = ent[i+1];
    end

    dsq_cell u_cell (
      .clk       (clk),
      .rst_n     (rst_n),
      .cmd       (cmd),
      .left_ent  (left[i]),
      .left_keep (left_keep[i]),
      .right_ent (right[i]),
      .ent_o     (ent[i]),
      .keep_o    (keep[i]),
      .due_o     (due_o[i])
    );

    assign ent_o[i]   = ent[i];
    assign valid_o[i] = ent[i].valid;
  end

endmodule
`default_nettype wire

/* rtl/deadline_sleep_queue_top.sv */
// Sleep request: after the transfer, S_ADD forms the saturated wake tick and S_INSERT does
// the ordered insert; the next input transfer is taken when the FSM is back in S_IDLE.
// Immediate or full reply: S_REPLY registers the result once the output register is free.
// Tick: S_POP pops each due head entry into the result register, one result per cycle while
// the output is free; a tick with no due entry returns straight to S_IDLE.
// Synchronous active-low reset clears tick counter, queue valid bits and control.
`timescale 1ns / 1ps
`default_nettype none
`include "deadline_sleep_queue_top_assert.svh"
module deadline_sleep_queue_top import dsq_pkg::*; (
  input  logic      clk,
  input  logic      rst_n,
  dsq_in_if.sink    in_ch,
  dsq_out_if.source out_ch
);

  state_t                 state_r, state_nxt;
  tick_t                  tick_r, tick_nxt;
  tick_t                  wake_r, wake_nxt;
  id_t                    id_r, id_nxt;
  logic [REQ_BITS-1:0]    ticks_r, ticks_nxt;
  status_t                status_r, status_nxt;

  logic                   out_valid_r, out_valid_nxt;
  logic [7:0]             out_id_r, out_id_nxt;
  status_t                out_status_r, out_status_nxt;
  tick_t                  out_tick_r, out_tick_nxt;
  logic                   out_last_r, out_last_nxt;

  cell_cmd_t              cmd;
  cell_op_t               op;
  entry_t                 ent [QUEUE_DEPTH];
  logic [QUEUE_DEPTH-1:0] chain_valid;
  logic [QUEUE_DEPTH-1:0] chain_due;
  logic [QUEUE_DEPTH-1:0] valid_inc;
  logic [TICK_BITS:0]     wake_sum;
  logic                   out_free;
  logic                   out_load;
  int                     occ;

  assign cmd      = '{op: op, key: wake_r, tick: tick_r, id: id_r};
  assign out_free = !out_valid_r || out_ch.ready;
  assign wake_sum = {1'b0, tick_r} + (TICK_BITS + 1)'(ticks_r);
  assign valid_inc = chain_valid + QUEUE_DEPTH'(1);
  assign occ      = $countones(chain_valid);

  dsq_chain u_chain (
    .clk     (clk),
    .rst_n   (rst_n),
    .cmd     (cmd),
    .ent_o   (ent),
    .valid_o (chain_valid),
    .due_o   (chain_due)
  );

  always_comb begin
    state_nxt      = state_r;
    tick_nxt       = tick_r;
    wake_nxt       = wake_r;
    id_nxt         = id_r;
    ticks_nxt      = ticks_r;
    status_nxt     = status_r;
    op             = CELL_HOLD;
    in_ch.ready    = 1'b0;
    out_load       = 1'b0;
    out_id_nxt     = out_id_r;
    out_status_nxt = out_status_r;
    out_tick_nxt   = out_tick_r;
    out_last_nxt   = out_last_r;
    case (state_r)
      S_IDLE: begin
        in_ch.ready = 1'b1;
        if (in_ch.valid) begin
          id_nxt    = id_t'(in_ch.thread_id);
          ticks_nxt = in_ch.sleep_ticks[REQ_BITS-1:0];
          if (in_ch.func == FN_TICK) begin
            tick_nxt  = tick_r + TICK_BITS'(1);
            state_nxt = S_POP;
          end else if (in_ch.sleep_ticks < 32'sd1) begin
            status_nxt = ST_IMMEDIATE;
            state_nxt  = S_REPLY;
          end else if (chain_valid[QUEUE_DEPTH-1]) begin
            status_nxt = ST_FULL;
            state_nxt  = S_REPLY;
          end else begin
            state_nxt = S_ADD;
          end
        end
      end
      S_ADD: begin
        wake_nxt  = wake_sum[TICK_BITS] ? '1 : wake_sum[TICK_BITS-1:0];
        state_nxt = S_INSERT;
      end
      S_INSERT: begin
        op        = CELL_INSERT;
        state_nxt = S_IDLE;
      end
      S_REPLY: begin
        if (out_free) begin
          out_load       = 1'b1;
          out_id_nxt     = 8'(id_r);
          out_status_nxt = status_r;
          out_tick_nxt   = tick_r;
          out_last_nxt   = 1'b1;
          state_nxt      = S_IDLE;
        end
      end
      S_POP: begin
        if (!chain_due[0]) begin
          state_nxt = S_IDLE;
        end else if (out_free) begin
          op             = CELL_POP;
          out_load       = 1'b1;
          out_id_nxt     = 8'(ent[0].id);
          out_status_nxt = ST_WOKEN;
          out_tick_nxt   = tick_r;
          out_last_nxt   = !chain_due[1];
          if (!chain_due[1]) begin
            state_nxt = S_IDLE;
          end
        end
      end
      default: begin
        state_nxt = S_IDLE;
      end
    endcase
    out_valid_nxt = out_load || (out_valid_r && !out_ch.ready);
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= S_IDLE;
      tick_r      <= '0;
      out_valid_r <= 1'b0;
    end else begin
      state_r     <= state_nxt;
      tick_r      <= tick_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end

  always_ff @(posedge clk) begin
    wake_r       <= wake_nxt;
    id_r         <= id_nxt;
    ticks_r      <= ticks_nxt;
    status_r     <= status_nxt;
    out_id_r     <= out_id_nxt;
    out_status_r <= out_status_nxt;
    out_tick_r   <= out_tick_nxt;
    out_last_r   <= out_last_nxt;
  end

  assign out_ch.valid    = out_valid_r;
  assign out_ch.woken_id = out_id_r;
  assign out_ch.status   = out_status_r;
  assign out_ch.now_tick = out_tick_r;
  assign out_ch.last     = out_last_r;

  `DSQ_ASSERT_NOW(a_queue_packed, 1'b1, (valid_inc & chain_valid) == '0, "queue has a hole")
  `DSQ_ASSERT_NOW(a_head_sorted, chain_valid[1], ent[0].wake <= ent[1].wake, "head out of order")
  `DSQ_ASSERT_NEXT(a_insert_grows, state_r == S_INSERT, occ == $past(occ) + 1, "insert lost")
  `DSQ_ASSERT_NEXT(a_pop_shrinks, op == CELL_POP, occ + 1 == $past(occ), "pop miscount")

endmodule
`default_nettype wire

/* bench/wake_checker.sv */
`timescale 1ns / 1ps
module wake_checker import dsq_pkg::*; (
  input  logic               clk,
  input  logic               rst_n,
  input  logic               in_valid,
  input  logic               in_ready,
  input  logic               in_func,
  input  id_t                in_thread_id,
  input  logic signed [31:0] in_sleep_ticks,
  input  logic               out_valid,
  input  logic               out_ready,
  input  id_t                out_woken_id,
  input  logic [1:0]         out_status,
  input  tick_t              out_now_tick,
  input  logic               out_last,
  output int                 mismatches,
  output int                 results_due
);

  typedef struct packed {
    id_t     id;
    status_t status;
    tick_t   now;
    logic    last;
  } wake_result_t;

  typedef struct packed {
    tick_t wake;
    id_t   id;
  } sleeper_t;

  localparam tick_t TICK_MAX = '1;

  tick_t        clock_ticks;
  sleeper_t     sleepers[$];
  wake_result_t wake_expect[$];

  task automatic predict_wakeups(input logic fn, input id_t id, input logic signed [31:0] req);
    logic [63:0]  sum;
    int           pos;
    wake_result_t res;
    if (fn != FN_TICK) begin
      if (req <= 0) begin
        res = '{id, ST_IMMEDIATE, clock_ticks, 1'b1};
        wake_expect.push_back(res);
      end else if (sleepers.size() >= QUEUE_DEPTH) begin
        res = '{id, ST_FULL, clock_ticks, 1'b1};
        wake_expect.push_back(res);
      end else begin
        sum = {1'b0, clock_ticks} + {32'd0, req};
        if (sum > {1'b0, TICK_MAX}) sum = {1'b0, TICK_MAX};
        pos = 0;
        while (pos < sleepers.size() && sleepers[pos].wake <= sum[62:0]) pos++;
        sleepers.insert(pos, sleeper_t'{sum[62:0], id});
      end
    end else begin
      clock_ticks = clock_ticks + 1'b1;
      while (sleepers.size() > 0 && sleepers[0].wake <= clock_ticks) begin
        res = '{sleepers[0].id, ST_WOKEN, clock_ticks, 1'b0};
        void'(sleepers.pop_front());
        res.last = (sleepers.size() == 0) || (sleepers[0].wake > clock_ticks);
        wake_expect.push_back(res);
      end
    end
  endtask

  always @(posedge clk) begin : monitor
    wake_result_t exp;
    if (!rst_n) begin
      clock_ticks = '0;
      sleepers.delete();
      wake_expect.delete();
      mismatches = 0;
    end else begin
      if (out_valid && out_ready) begin
        if (wake_expect.size() == 0) begin
          $display("%0t: unexpected result id=%0d status=%0d now=%0d last=%0d", $time,
                   out_woken_id, out_status, out_now_tick, out_last);
          mismatches++;
        end else begin
          exp = wake_expect.pop_front();
          if (out_woken_id !== exp.id || out_status !== exp.status ||
              out_now_tick !== exp.now || out_last !== exp.last) begin
            $display("%0t: mismatch expected id=%0d status=%0d now=%0d last=%0d", $time,
                     exp.id, exp.status, exp.now, exp.last);
            $display("%0t:          actual   id=%0d status=%0d now=%0d last=%0d", $time,
                     out_woken_id, out_status, out_now_tick, out_last);
            mismatches++;
          end
        end
      end
      if (in_valid && in_ready) predict_wakeups(in_func, in_thread_id, in_sleep_ticks);
    end
    results_due = wake_expect.size();
  end

endmodule

/* bench/testbench.sv */
`timescale 1ns / 1ps
module testbench;
  import dsq_pkg::*;

  localparam logic FN_SLEEP       = ~FN_TICK;
  localparam int   ITEM_TARGET    = 380;
  localparam int   WATCHDOG_LIMIT = 2000;
  localparam int   DRAIN_CYCLES   = 40;

  logic clk   = 1'b0;
  logic rst_n = 1'b0;
  logic steady = 1'b0;
  int   sent = 0;
  int   quiet;
  int   mismatches;
  int   results_due;

  dsq_in_if  in_ch();
  dsq_out_if out_ch();

  deadline_sleep_queue_top dut (
    .clk    (clk),
    .rst_n  (rst_n),
    .in_ch  (in_ch),
    .out_ch (out_ch)
  );

  wake_checker chk (
    .clk            (clk),
    .rst_n          (rst_n),
    .in_valid       (in_ch.valid),
    .in_ready       (in_ch.ready),
    .in_func        (in_ch.func),
    .in_thread_id   (in_ch.thread_id),
    .in_sleep_ticks (in_ch.sleep_ticks),
    .out_valid      (out_ch.valid),
    .out_ready      (out_ch.ready),
    .out_woken_id   (out_ch.woken_id),
    .out_status     (out_ch.status),
    .out_now_tick   (out_ch.now_tick),
    .out_last       (out_ch.last),
    .mismatches     (mismatches),
    .results_due    (results_due)
  );

  always #4 clk = ~clk;

  function automatic int pick_gap();
    int roll;
    if (steady) return 0;
    roll = $urandom_range(0, 19);
    if (roll == 0) return $urandom_range(15, 60);
    if (roll <= 9) return 0;
    return $urandom_range(1, 3);
  endfunction

  task automatic send_item(input logic fn, input id_t id, input logic signed [31:0] req);
    int gap;
    gap = pick_gap();
    if (gap > 0) begin
      in_ch.valid = 1'b0;
      repeat (gap) @(negedge clk);
    end
    in_ch.valid       = 1'b1;
    in_ch.func        = fn;
    in_ch.thread_id   = id;
    in_ch.sleep_ticks = req;
    do @(posedge clk); while (!in_ch.ready);
    @(negedge clk);
    sent++;
  endtask

  function automatic logic [31:0] negative_ticks();
    return {1'b1, 31'($urandom)};
  endfunction

  initial begin : out_pacing
    int stall;
    out_ch.ready = 1'b0;
    wait (rst_n);
    @(negedge clk);
    forever begin
      out_ch.ready = 1'b1;
      repeat ($urandom_range(1, 12)) @(negedge clk);
      stall = pick_gap();
      if (stall > 0) begin
        out_ch.ready = 1'b0;
        repeat (stall) @(negedge clk);
      end
    end
  end

  always @(posedge clk) begin
    if (!rst_n) begin
      quiet <= 0;
    end else if ((in_ch.valid && in_ch.ready) || (out_ch.valid && out_ch.ready)) begin
      quiet <= 0;
    end else begin
      quiet <= quiet + 1;
      if (quiet >= WATCHDOG_LIMIT) begin
        $display("Regression FAIL");
        $finish;
      end
    end
  end

  initial begin : stimulus
    bit paused;
    in_ch.valid       = 1'b0;
    in_ch.func        = FN_TICK;
    in_ch.thread_id   = '0;
    in_ch.sleep_ticks = '0;
    paused = 1'b0;
    repeat (9) @(negedge clk);
    rst_n = 1'b1;
    @(negedge clk);

    send_item(FN_SLEEP, 8'h00, 32'sd0);
    send_item(FN_SLEEP, 8'hFF, 32'sh8000_0000);
    send_item(FN_SLEEP, 8'hAA, -32'sd1);
    for (int i = 0; i < QUEUE_DEPTH; i++) send_item(FN_SLEEP, id_t'(i * 17), 32'sd1);
    send_item(FN_SLEEP, 8'h55, 32'sd5);
    send_item(FN_TICK, 8'h00, 32'sd0);
    send_item(FN_SLEEP, 8'h10, 32'sd3);
    send_item(FN_SLEEP, 8'h11, 32'sd1);
    repeat (3) send_item(FN_TICK, id_t'($urandom), $urandom);

    while (sent < ITEM_TARGET) begin
      steady = ($urandom_range(0, 7) == 0);
      if (!paused && sent >= ITEM_TARGET / 2) begin
        in_ch.valid = 1'b0;
        while (results_due != 0) @(negedge clk);
        paused = 1'b1;
      end
      case ($urandom_range(0, 9))
        0, 1, 2, 3, 4: begin
          repeat ($urandom_range(1, 8))
            send_item(FN_SLEEP, id_t'($urandom), $urandom_range(1, 6));
          repeat ($urandom_range(1, 6)) send_item(FN_TICK, id_t'($urandom), $urandom);
        end
        5: begin
          repeat (QUEUE_DEPTH + 1)
            send_item(FN_SLEEP, id_t'($urandom),
                      $urandom_range(0, 1) ? 1 : $urandom_range(1, 3));
          repeat (3) send_item(FN_TICK, id_t'($urandom), $urandom);
        end
        6, 7: begin
          repeat ($urandom_range(1, 4))
            send_item(FN_SLEEP, id_t'($urandom),
                      ($urandom_range(0, 3) == 0) ? 0 : negative_ticks());
        end
        default: begin
          repeat ($urandom_range(1, 6))
            send_item(1'($urandom_range(0, 1)), id_t'($urandom),
                      $urandom_range(0, 1) ? negative_ticks() : $urandom_range(0, 20));
        end
      endcase
    end
    steady = 1'b0;
    send_item(FN_SLEEP, id_t'($urandom), 32'sh7FFF_FFFF);
    in_ch.valid = 1'b0;

    while (results_due != 0) @(negedge clk);
    repeat (DRAIN_CYCLES) @(posedge clk);
    if (mismatches == 0 && results_due == 0) begin
      $display("Regression PASS");
    end else begin
      $display("Regression FAIL");
    end
    $finish;
  end

endmodule

/* sim.f */
+incdir+rtl
rtl/dsq_pkg.sv
rtl/dsq_if.sv
rtl/dsq_cell.sv
rtl/dsq_chain.sv
rtl/deadline_sleep_queue_top.sv
bench/wake_checker.sv
bench/testbench.sv
